### rtl/sdil_pkg.sv
// Shared types and codes for the sorted descending insert list.
package sdil_pkg;

	localparam int KEY_W  = 10;
	localparam int TERM_W = 4;
	localparam int ID_W   = 8;
	localparam int DATA_W = 24;

	// Result status codes carried on the master-side tuser.
	typedef enum logic [1:0] {
		STAT_INSERTED = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_ENTRY    = 2'd2,
		STAT_EMPTY    = 2'd3
	} sdil_status_t;

	// Input kind carried on the slave-side tuser.
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_DRAIN  = 1'b1
	} sdil_mode_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} sdil_state_t;

	// One stored record.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TERM_W-1:0] term;
		logic [KEY_W-1:0]  key;
	} sdil_rec_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} sdil_ctl_t;

endpackage

### rtl/sdil_cell.sv
// One cell of the sorted chain: holds a record and shifts with its neighbors.
module sdil_cell
	import sdil_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sdil_ctl_t ctl,
	input  sdil_rec_t new_rec,
	input  sdil_rec_t prev_rec,
	input  logic      prev_keep,
	input  logic      prev_valid,
	input  sdil_rec_t next_rec,
	input  logic      next_valid,
	output sdil_rec_t rec,
	output logic      valid,
	output logic      keep
);

	sdil_rec_t rec_q;
	logic      valid_q;

	// A cell keeps its record on insert when it holds a strictly larger key.
	assign keep  = valid_q && (rec_q.key > new_rec.key);
	assign rec   = rec_q;
	assign valid = valid_q;

	// Valid bit: filled from the cell above on insert, from below on pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			valid_q <= prev_valid;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end
	end

	// Record: hold, take the new record, or shift down; on pop shift up.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!keep) begin
				if (prev_keep) begin
					rec_q <= new_rec;
				end else begin
					rec_q <= prev_rec;
				end
			end
		end else if (ctl.pop) begin
			rec_q <= next_rec;
		end
	end

endmodule

### rtl/sorted_descending_insert_list.sv
// Top level of the sorted descending insert list built as a chain of cells.
//
//  Channel | Direction | tdata (low bit up)                  | tuser      | tlast
//  s_axis  | in        | credit_key, term_value, record_id    | mode       | -
//  m_axis  | out       | out_key, out_term, out_id           | status     | last_of_run
//
// An insert, a refused insert or a drain of an empty list gives one result;
// inserts follow each other every cycle while results are taken.
// A drain of N entries gives N results: while the output is free, the chain shifts
// one entry a cycle toward cell 0, which feeds the output register. No input is
// taken during a drain. Reset empties the list at once by clearing the valid bit
// of every cell. A stalled output holds its result; the chain waits with it.
module sorted_descending_insert_list
	import sdil_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // credit_key, term_value, record_id, zero pad
	input  logic              s_axis_tuser,  // mode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // out_key, out_term, out_id, zero pad
	output logic [1:0]        m_axis_tuser,  // status
	output logic              m_axis_tlast
);

	sdil_state_t state_q, state_d;
	sdil_ctl_t   ctl;
	sdil_rec_t   new_rec;
	sdil_rec_t   rec_w      [CAPACITY];
	sdil_rec_t   prev_rec_w [CAPACITY];
	sdil_rec_t   next_rec_w [CAPACITY];
	logic [CAPACITY-1:0] valid_vec, keep_vec, prev_keep_vec, prev_valid_vec, next_valid_vec;

	logic         out_valid_q;
	sdil_rec_t    out_rec_q;
	sdil_status_t out_stat_q;
	logic         out_last_q;

	logic         out_free, in_xfer, full;
	logic         load_out;
	sdil_rec_t    load_rec;
	sdil_status_t load_stat;
	logic         load_last;

	assign new_rec = sdil_rec_t'(s_axis_tdata[KEY_W+TERM_W+ID_W-1:0]);
	assign full    = valid_vec[CAPACITY-1];
	assign out_free = !out_valid_q || m_axis_tready;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;

	// Neighbor wiring: cell 0 always receives the new record, the last cell pops empty.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_link
		if (i == 0) begin : g_first
			assign prev_rec_w[i]     = new_rec;
			assign prev_keep_vec[i]  = 1'b0;
			assign prev_valid_vec[i] = 1'b1;
		end else begin : g_mid
			assign prev_rec_w[i]     = rec_w[i-1];
			assign prev_keep_vec[i]  = keep_vec[i-1];
			assign prev_valid_vec[i] = valid_vec[i-1];
		end
		if (i == CAPACITY-1) begin : g_last
			assign next_rec_w[i]     = rec_w[i];
			assign next_valid_vec[i] = 1'b0;
		end else begin : g_inner
			assign next_rec_w[i]     = rec_w[i+1];
			assign next_valid_vec[i] = valid_vec[i+1];
		end

		sdil_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_rec    (new_rec),
			.prev_rec   (prev_rec_w[i]),
			.prev_keep  (prev_keep_vec[i]),
			.prev_valid (prev_valid_vec[i]),
			.next_rec   (next_rec_w[i]),
			.next_valid (next_valid_vec[i]),
			.rec        (rec_w[i]),
			.valid      (valid_vec[i]),
			.keep       (keep_vec[i])
		);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, chain commands and the result to load.
	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		load_rec      = '0;
		load_stat     = STAT_INSERTED;
		load_last     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = out_free;
				if (in_xfer) begin
					if (sdil_mode_t'(s_axis_tuser) == MODE_INSERT) begin
						load_out = 1'b1;
						if (full) begin
							load_stat = STAT_FULL;
						end else begin
							load_stat = STAT_INSERTED;
							ctl.ins   = 1'b1;
						end
					end else if (!valid_vec[0]) begin
						load_out  = 1'b1;
						load_stat = STAT_EMPTY;
					end else begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_rec  = rec_w[0];
					load_stat = STAT_ENTRY;
					load_last = !valid_vec[1];
					ctl.pop   = 1'b1;
					if (!valid_vec[1]) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rec_q  <= load_rec;
			out_stat_q <= load_stat;
			out_last_q <= load_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(DATA_W-KEY_W-TERM_W-ID_W){1'b0}}, out_rec_q};
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// Occupied cells always form an unbroken run starting at cell 0.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
		else $error("valid cells are not a contiguous prefix");

	// Loading the final drained entry leaves the list empty.
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && out_free && !valid_vec[1]) |=> (valid_vec == '0))
		else $error("list not empty after drain");

	// A refused insert leaves the chain untouched.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser == MODE_INSERT && full) |=> $stable(valid_vec))
		else $error("refused insert changed the list");

	// An accepted insert always occupies cell 0.
	a_insert_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser == MODE_INSERT && !full) |=> valid_vec[0])
		else $error("insert left cell 0 empty");
`endif

endmodule
